>>> rtl/bbe_pkg.sv
// Package for the bandwidth estimator: payload words, command and status
// structs between controller and datapath, fixed-point constants, clamp.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package bbe_pkg;

  localparam int unsigned BBE_QUEUE_DEPTH = 128;

  localparam logic [16:0] Q_0P8      = 17'd52429;
  localparam logic [16:0] Q_0P85     = 17'd55706;
  localparam logic [16:0] Q_0P9      = 17'd58982;
  localparam logic [16:0] Q_1P1      = 17'd72090;
  localparam logic [16:0] Q_1P2      = 17'd78643;
  localparam logic [16:0] Q_1P5      = 17'd98304;
  localparam logic [16:0] BYTE_SCALE = 17'd8000;

  localparam logic [2:0] MODE_INIT    = 3'd0;
  localparam logic [2:0] MODE_STARVE  = 3'd1;
  localparam logic [2:0] MODE_PROBE   = 3'd2;
  localparam logic [2:0] MODE_APPLIM  = 3'd3;
  localparam logic [2:0] MODE_BW      = 3'd4;

  localparam logic [1:0] TREND_STABLE = 2'd0;
  localparam logic [1:0] TREND_INC    = 2'd1;
  localparam logic [1:0] TREND_DEC    = 2'd2;

  typedef enum logic [1:0] {
    CFG_INIT, CFG_MIN, CFG_MAX, CFG_WIN
  } cfg_idx_t;

  typedef enum logic [3:0] {
    MUL_NONE, MUL_BYTES, MUL_RTT12, MUL_BW08, MUL_BTL085,
    MUL_DEL11, MUL_RTT15, MUL_SAFE085, MUL_RAW08, MUL_CUR09
  } mul_op_t;

  typedef enum logic { RD_HEAD, RD_BACK } rd_sel_t;
  typedef enum logic { Q_RTT, Q_BW } qsel_t;

  typedef struct packed {
    logic [39:0] sample_time;
    logic [23:0] rcvd_bytes;
    logic [19:0] raw_rtt;
    logic [23:0] buffer_level;
    logic [31:0] smoothed_throughput;
    logic [19:0] smoothed_rtt;
    logic [19:0] jitter;
  } in_word_t;

  typedef struct packed {
    logic [25:0] bitrate_estimate;
    logic [1:0]  trend_code;
    logic [2:0]  mode_code;
    logic        sample_accepted;
  } out_word_t;

  typedef struct packed {
    logic    load_in;
    logic    gap_step;
    logic    div_start;
    mul_op_t mul_op;
    rd_sel_t rd_sel;
    logic    front1_cap;
    logic    app_cap;
    qsel_t   q_sel;
    logic    pop;
    logic    push;
    logic    exp_pop;
    logic    front2_cap;
    logic    safe_cap;
    logic    decide;
    logic    trend_cap;
    logic    load_out;
  } bbe_cmd_t;

  typedef struct packed {
    logic gap_ok;
    logic div_done;
    logic q_empty;
    logic pop_hit;
    logic exp_hit;
    logic rtt_nz;
    logic bw_need;
  } bbe_stat_t;

  function automatic logic [25:0] clamp_rate(input logic [31:0] v,
                                             input logic [25:0] lo,
                                             input logic [25:0] hi);
    logic [31:0] r;
    r = v;
    if (r < {6'd0, lo}) r = {6'd0, lo};
    if (r > {6'd0, hi}) r = {6'd0, hi};
    return r[25:0];
  endfunction

endpackage
`default_nettype wire

>>> rtl/bbe_datapath.sv
// Datapath: input and config registers, shared multiplier, bit-serial divider,
// window queues in local memories, estimate state and output register.
// Depends on bbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbe_datapath
  import bbe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = BBE_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_word_t    in_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [25:0] cfg_data,
  input  wire bbe_cmd_t    cmd,
  output bbe_stat_t        st,
  output out_word_t        out_data
);

  localparam int PW    = $clog2(QUEUE_DEPTH);
  localparam int SW    = PW + 1;
  localparam int DVD_W = 37;
  localparam int DCW   = $clog2(DVD_W + 1);
  localparam logic [SW-1:0] QD_S = SW'(QUEUE_DEPTH);

  function automatic logic [PW-1:0] wrap(input logic [SW-1:0] s);
    logic [SW-1:0] r;
    r = (s >= QD_S) ? s - QD_S : s;
    return r[PW-1:0];
  endfunction

  function automatic logic [PW-1:0] inc(input logic [PW-1:0] h);
    return (h == PW'(QUEUE_DEPTH - 1)) ? '0 : h + 1'b1;
  endfunction

  in_word_t    in_r;
  out_word_t   out_r;
  logic [39:0] last_time_r;
  logic [12:0] gap_r;
  logic        acc_r;
  logic [25:0] min_r, max_r, cur_r;
  logic [15:0] wl_r;
  logic [1:0]  trend_r;
  logic [2:0]  mode_r;
  logic [48:0] prod_r, prod_a_r, prod_b_r, prod_c_r;
  mul_op_t     pop_r;
  logic [DVD_W-1:0] dvd_r;
  logic [12:0] rem_r;
  logic [DCW-1:0] div_cnt_r;
  logic [19:0] rtprop_r;
  logic [31:0] prevbw_r, btl_r, safe_r;
  logic        app_lim_r, starv_r, probe_r;

  logic [31:0] bw_val  [QUEUE_DEPTH];
  logic [39:0] bw_tim  [QUEUE_DEPTH];
  logic [19:0] rtt_val [QUEUE_DEPTH];
  logic [39:0] rtt_tim [QUEUE_DEPTH];
  logic [31:0] bw_val_q;
  logic [39:0] bw_tim_q, rtt_tim_q;
  logic [19:0] rtt_val_q;
  logic [PW-1:0] bw_head_r, rtt_head_r;
  logic [SW-1:0] bw_cnt_r, rtt_cnt_r;

  logic [39:0] t, gap_full;
  logic [31:0] fromb, deliv, raw, mul_a, bw_front;
  logic [19:0] rtt, rtt_front;
  logic [16:0] mul_f;
  logic [PW-1:0] bw_ra, rtt_ra, a_head, ph, wa;
  logic [SW-1:0] a_cnt, pc;
  logic        full;
  logic [39:0] a_tim;
  logic [13:0] rem_sh;
  logic        ge;
  logic [31:0] safe0;
  logic [32:0] ceil_v;

  assign t        = in_r.sample_time;
  assign gap_full = (last_time_r != 40'd0 && t > last_time_r) ? t - last_time_r : 40'd1000;
  assign fromb    = (|dvd_r[36:32]) ? 32'hFFFF_FFFF : dvd_r[31:0];
  assign deliv    = (in_r.smoothed_throughput != 32'd0) ? in_r.smoothed_throughput : fromb;
  assign raw      = (in_r.rcvd_bytes != 24'd0) ? fromb : deliv;
  assign rtt      = (in_r.smoothed_rtt != 20'd0) ? in_r.smoothed_rtt : in_r.raw_rtt;

  assign bw_front  = (bw_cnt_r != '0) ? bw_val_q : 32'd0;
  assign rtt_front = (rtt_cnt_r != '0) ? rtt_val_q : 20'd0;

  assign bw_ra  = (cmd.rd_sel == RD_BACK) ? wrap(SW'(bw_head_r) + bw_cnt_r - 1'b1) : bw_head_r;
  assign rtt_ra = (cmd.rd_sel == RD_BACK) ? wrap(SW'(rtt_head_r) + rtt_cnt_r - 1'b1)
                                          : rtt_head_r;

  assign a_head = (cmd.q_sel == Q_BW) ? bw_head_r : rtt_head_r;
  assign a_cnt  = (cmd.q_sel == Q_BW) ? bw_cnt_r : rtt_cnt_r;
  assign a_tim  = (cmd.q_sel == Q_BW) ? bw_tim_q : rtt_tim_q;
  assign full   = (a_cnt == QD_S);
  assign ph     = full ? inc(a_head) : a_head;
  assign pc     = full ? QD_S - 1'b1 : a_cnt;
  assign wa     = wrap(SW'(ph) + pc);

  assign rem_sh = {rem_r, dvd_r[DVD_W-1]};
  assign ge     = rem_sh >= {1'b0, gap_r};
  assign safe0  = prod_a_r[47:16];
  assign ceil_v = prod_b_r[48:16];

  always_comb begin
    st.gap_ok   = gap_full >= 40'd100 && gap_full <= 40'd5000;
    st.div_done = div_cnt_r == '0;
    st.q_empty  = a_cnt == '0;
    st.pop_hit  = (cmd.q_sel == Q_BW) ? (bw_val_q <= deliv) : (rtt_val_q >= rtt);
    st.exp_hit  = ({1'b0, a_tim} + 41'(wl_r)) < {1'b0, t};
    st.rtt_nz   = rtt != 20'd0;
    st.bw_need  = deliv != 32'd0 && !app_lim_r;
  end

  always_comb begin
    case (cmd.mul_op)
      MUL_BYTES:   begin mul_a = {8'd0, in_r.rcvd_bytes}; mul_f = BYTE_SCALE; end
      MUL_RTT12:   begin mul_a = {12'd0, rtprop_r}; mul_f = Q_1P2; end
      MUL_BW08:    begin mul_a = prevbw_r; mul_f = Q_0P8; end
      MUL_BTL085:  begin mul_a = btl_r; mul_f = Q_0P85; end
      MUL_DEL11:   begin mul_a = deliv; mul_f = Q_1P1; end
      MUL_RTT15:   begin mul_a = {12'd0, rtprop_r}; mul_f = Q_1P5; end
      MUL_SAFE085: begin mul_a = safe_r; mul_f = Q_0P85; end
      MUL_RAW08:   begin mul_a = raw; mul_f = Q_0P8; end
      MUL_CUR09:   begin mul_a = {6'd0, cur_r}; mul_f = Q_0P9; end
      default:     begin mul_a = 32'd0; mul_f = 17'd0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= 40'd0;
      min_r       <= 26'd100000;
      max_r       <= 26'd50000000;
      wl_r        <= 16'd10000;
      cur_r       <= 26'd1000000;
      trend_r     <= TREND_STABLE;
      mode_r      <= MODE_INIT;
      pop_r       <= MUL_NONE;
      div_cnt_r   <= '0;
      bw_head_r   <= '0;
      bw_cnt_r    <= '0;
      rtt_head_r  <= '0;
      rtt_cnt_r   <= '0;
    end else begin
      pop_r <= cmd.mul_op;
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_INIT: begin
            if (mode_r == MODE_INIT) cur_r <= cfg_data;
          end
          CFG_MIN: min_r <= cfg_data;
          CFG_MAX: max_r <= cfg_data;
          CFG_WIN: wl_r  <= cfg_data[15:0];
          default: ;
        endcase
      end
      if (cmd.gap_step) last_time_r <= t;
      if (cmd.div_start) div_cnt_r <= DCW'(DVD_W);
      else if (div_cnt_r != '0) div_cnt_r <= div_cnt_r - 1'b1;
      if (cmd.q_sel == Q_BW) begin
        if (cmd.pop) bw_cnt_r <= bw_cnt_r - 1'b1;
        if (cmd.push) begin
          bw_head_r <= ph;
          bw_cnt_r  <= pc + 1'b1;
        end
        if (cmd.exp_pop) begin
          bw_head_r <= inc(bw_head_r);
          bw_cnt_r  <= bw_cnt_r - 1'b1;
        end
      end else begin
        if (cmd.pop) rtt_cnt_r <= rtt_cnt_r - 1'b1;
        if (cmd.push) begin
          rtt_head_r <= ph;
          rtt_cnt_r  <= pc + 1'b1;
        end
        if (cmd.exp_pop) begin
          rtt_head_r <= inc(rtt_head_r);
          rtt_cnt_r  <= rtt_cnt_r - 1'b1;
        end
      end
      if (cmd.decide) begin
        if (starv_r) begin
          mode_r <= MODE_STARVE;
          cur_r  <= clamp_rate(prod_b_r[47:16], min_r, max_r);
        end else if (probe_r) begin
          mode_r <= MODE_PROBE;
          cur_r  <= clamp_rate(prod_a_r[47:16], min_r, max_r);
        end else if (app_lim_r) begin
          mode_r <= MODE_APPLIM;
        end else begin
          mode_r <= MODE_BW;
          cur_r  <= clamp_rate(safe_r, min_r, max_r);
        end
      end
      if (cmd.trend_cap) begin
        if (deliv > {6'd0, cur_r}) trend_r <= TREND_INC;
        else if ({1'b0, deliv, 16'd0} < prod_a_r) trend_r <= TREND_DEC;
        else trend_r <= TREND_STABLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_r <= in_data;
    if (cmd.gap_step) begin
      gap_r <= gap_full[12:0];
      acc_r <= st.gap_ok;
    end
    prod_r <= mul_a * mul_f;
    case (pop_r)
      MUL_BYTES, MUL_RTT12, MUL_BTL085, MUL_SAFE085, MUL_CUR09: prod_a_r <= prod_r;
      MUL_BW08, MUL_DEL11, MUL_RAW08:                         prod_b_r <= prod_r;
      MUL_RTT15:                                              prod_c_r <= prod_r;
      default: ;
    endcase
    if (cmd.div_start) begin
      dvd_r <= prod_a_r[DVD_W-1:0];
      rem_r <= 13'd0;
    end else if (div_cnt_r != '0) begin
      rem_r <= ge ? 13'(rem_sh - {1'b0, gap_r}) : rem_sh[12:0];
      dvd_r <= {dvd_r[DVD_W-2:0], ge};
    end
    if (cmd.front1_cap) begin
      rtprop_r <= rtt_front;
      prevbw_r <= bw_front;
    end
    if (cmd.front2_cap) begin
      rtprop_r <= rtt_front;
      btl_r    <= (bw_front != 32'd0) ? bw_front : {6'd0, cur_r};
    end
    if (cmd.app_cap) begin
      app_lim_r <= rtprop_r != 20'd0 && rtt != 20'd0
                   && ({2'd0, rtt, 16'd0} <= {1'b0, prod_a_r[36:0]} + 38'd20971520)
                   && in_r.jitter < 20'd480 && in_r.buffer_level > 24'd500
                   && ({1'b0, deliv, 16'd0} < prod_b_r);
    end
    if (cmd.safe_cap) begin
      safe_r  <= (deliv != 32'd0 && ceil_v < {1'b0, safe0}) ? ceil_v[31:0] : safe0;
      starv_r <= in_r.buffer_level != 24'd0 && in_r.buffer_level < 24'd300
                 && raw < {6'd0, cur_r};
      probe_r <= rtt != 20'd0 && rtprop_r != 20'd0
                 && ({1'b0, rtt, 16'd0} > prod_c_r[36:0]);
    end
    if (cmd.load_out) begin
      out_r.bitrate_estimate <= cur_r;
      out_r.trend_code       <= trend_r;
      out_r.mode_code        <= mode_r;
      out_r.sample_accepted  <= acc_r;
    end
  end

  always_ff @(posedge clk) begin
    bw_val_q  <= bw_val[bw_ra];
    bw_tim_q  <= bw_tim[bw_ra];
    rtt_val_q <= rtt_val[rtt_ra];
    rtt_tim_q <= rtt_tim[rtt_ra];
    if (cmd.push && cmd.q_sel == Q_BW) begin
      bw_val[wa] <= deliv;
      bw_tim[wa] <= t;
    end
    if (cmd.push && cmd.q_sel == Q_RTT) begin
      rtt_val[wa] <= rtt;
      rtt_tim[wa] <= t;
    end
  end

  assign out_data = out_r;

endmodule
`default_nettype wire

>>> rtl/bbe_ctrl.sv
// Controller: sequences one sample through gap check, division, queue walks
// and estimate update, and owns the input and output handshakes.
// Depends on bbe_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bbe_ctrl
  import bbe_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  wire logic      out_stall,
  input  wire bbe_stat_t st,
  output bbe_cmd_t       cmd
);

  typedef enum logic [5:0] {
    S_IDLE, S_GAP, S_MBYTES, S_MW1, S_DIVST, S_DIV, S_FR1, S_FR1W,
    S_MAPP1, S_MAPP2, S_MAPPW, S_APPL, S_QSEL, S_POPRD, S_POPCMP, S_PUSH,
    S_EXPRD, S_EXPCMP, S_FR2, S_FR2W, S_MBTL, S_MDEL, S_MRTT, S_MW3,
    S_SAFE, S_MSAFE, S_MRAW, S_MW4, S_DECIDE, S_MCUR, S_MW5, S_TREND, S_DONE
  } state_t;

  state_t state_r;
  qsel_t  qsel_r;
  logic   out_valid_r;
  logic   slot_free;

  assign slot_free = !out_valid_r || !out_stall;
  assign in_stall  = state_r != S_IDLE;
  assign out_valid = out_valid_r;

  always_comb begin
    cmd            = '0;
    cmd.mul_op     = MUL_NONE;
    cmd.rd_sel     = RD_HEAD;
    cmd.q_sel      = qsel_r;
    case (state_r)
      S_IDLE:   cmd.load_in    = in_valid;
      S_GAP:    cmd.gap_step   = 1'b1;
      S_MBYTES: cmd.mul_op     = MUL_BYTES;
      S_DIVST:  cmd.div_start  = 1'b1;
      S_FR1W:   cmd.front1_cap = 1'b1;
      S_MAPP1:  cmd.mul_op     = MUL_RTT12;
      S_MAPP2:  cmd.mul_op     = MUL_BW08;
      S_APPL:   cmd.app_cap    = 1'b1;
      S_POPRD:  cmd.rd_sel     = RD_BACK;
      S_POPCMP: cmd.pop        = st.pop_hit;
      S_PUSH:   cmd.push       = 1'b1;
      S_EXPCMP: cmd.exp_pop    = st.exp_hit;
      S_FR2W:   cmd.front2_cap = 1'b1;
      S_MBTL:   cmd.mul_op     = MUL_BTL085;
      S_MDEL:   cmd.mul_op     = MUL_DEL11;
      S_MRTT:   cmd.mul_op     = MUL_RTT15;
      S_SAFE:   cmd.safe_cap   = 1'b1;
      S_MSAFE:  cmd.mul_op     = MUL_SAFE085;
      S_MRAW:   cmd.mul_op     = MUL_RAW08;
      S_DECIDE: cmd.decide     = 1'b1;
      S_MCUR:   cmd.mul_op     = MUL_CUR09;
      S_TREND:  cmd.trend_cap  = 1'b1;
      S_DONE:   cmd.load_out   = slot_free;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      qsel_r      <= Q_RTT;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE:   if (in_valid) state_r <= S_GAP;
        S_GAP:    state_r <= st.gap_ok ? S_MBYTES : S_DONE;
        S_MBYTES: state_r <= S_MW1;
        S_MW1:    state_r <= S_DIVST;
        S_DIVST:  state_r <= S_DIV;
        S_DIV:    if (st.div_done) state_r <= S_FR1;
        S_FR1:    state_r <= S_FR1W;
        S_FR1W:   state_r <= S_MAPP1;
        S_MAPP1:  state_r <= S_MAPP2;
        S_MAPP2:  state_r <= S_MAPPW;
        S_MAPPW:  state_r <= S_APPL;
        S_APPL:   state_r <= S_QSEL;
        S_QSEL: begin
          if (st.rtt_nz) begin
            qsel_r  <= Q_RTT;
            state_r <= S_POPRD;
          end else if (st.bw_need) begin
            qsel_r  <= Q_BW;
            state_r <= S_POPRD;
          end else begin
            state_r <= S_FR2;
          end
        end
        S_POPRD:  state_r <= st.q_empty ? S_PUSH : S_POPCMP;
        S_POPCMP: state_r <= st.pop_hit ? S_POPRD : S_PUSH;
        S_PUSH:   state_r <= S_EXPRD;
        S_EXPRD, S_EXPCMP: begin
          if ((state_r == S_EXPRD && !st.q_empty) || (state_r == S_EXPCMP && st.exp_hit)) begin
            state_r <= (state_r == S_EXPRD) ? S_EXPCMP : S_EXPRD;
          end else if (qsel_r == Q_RTT && st.bw_need) begin
            qsel_r  <= Q_BW;
            state_r <= S_POPRD;
          end else begin
            state_r <= S_FR2;
          end
        end
        S_FR2:    state_r <= S_FR2W;
        S_FR2W:   state_r <= S_MBTL;
        S_MBTL:   state_r <= S_MDEL;
        S_MDEL:   state_r <= S_MRTT;
        S_MRTT:   state_r <= S_MW3;
        S_MW3:    state_r <= S_SAFE;
        S_SAFE:   state_r <= S_MSAFE;
        S_MSAFE:  state_r <= S_MRAW;
        S_MRAW:   state_r <= S_MW4;
        S_MW4:    state_r <= S_DECIDE;
        S_DECIDE: state_r <= S_MCUR;
        S_MCUR:   state_r <= S_MW5;
        S_MW5:    state_r <= S_TREND;
        S_TREND:  state_r <= S_DONE;
        S_DONE: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default:  state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

>>> rtl/bbr_bandwidth_estimator.sv
// Bandwidth and min-RTT estimator, one sample at a time, one result word each.
// An accepted sample runs through a 37-step bit-serial divide and the queue walks, where
// each entry popped or expired costs a read state and a compare state; a rejected sample
// goes from the gap check straight to the result. An output stall holds back the result.
// A new sample is taken only once the last one is through; it is taken while a result waits.
// Reset (synchronous, rst_n low): state, config and estimate registers to defaults, both queues empty.
`timescale 1ns / 1ps
`default_nettype none
module bbr_bandwidth_estimator
  import bbe_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = BBE_QUEUE_DEPTH
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire in_word_t    in_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output out_word_t        out_data,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [25:0] cfg_data
);

  bbe_cmd_t  cmd;
  bbe_stat_t st;

  bbe_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  bbe_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block not busy after taking a word");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result word without a sample in work");

  a_push_one_hot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.pop, cmd.push, cmd.exp_pop}))
    else $error("conflicting queue commands");

endmodule
`default_nettype wire
